// ===== hdl/bapr_pkg.sv =====
// Shared definitions for the block aligned range partition.
// Holds field widths, status codes, register indexes and parameter defaults.
// No dependencies.
`default_nettype none

package bapr_pkg;

   // Fixed field widths
   localparam int BS_WIDTH       = 16;
   localparam int STATUS_WIDTH   = 3;
   localparam int CSR_ADDR_WIDTH = 1;

   // Parameter defaults for the top level
   localparam int ADDR_WIDTH_DEFAULT  = 32;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // Result status codes
   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK               = 3'd0,
      ST_BLOCK_ZERO       = 3'd1,
      ST_NOT_MULTIPLE     = 3'd2,
      ST_COUNT_ZERO       = 3'd3,
      ST_END_BEFORE_START = 3'd4,
      ST_INDEX_RANGE      = 3'd5
   } status_type;

   // Configuration register indexes
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_BLOCK_SIZE    = 1'b0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_SEGMENT_COUNT = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/bapr_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit per item and passes
// the item on to the next cell. Side data rides along unchanged.
// Depends on nothing outside this file.
`default_nettype none

module bapr_div_cell #(
   parameter int N = 32,   // dividend and quotient width
   parameter int D = 16,   // divisor and remainder width
   parameter int S = 8     // side payload width
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire logic         in_valid,
   input  wire logic [D-1:0] in_rem,
   input  wire logic [N-1:0] in_dvd,
   input  wire logic [S-1:0] in_side,
   input  wire logic [D-1:0] divisor,
   output logic              out_valid,
   output logic [D-1:0]      out_rem,
   output logic [N-1:0]      out_dvd,
   output logic [S-1:0]      out_side
);

   logic [D:0]   trial;
   logic [D+1:0] diff;
   logic         borrow;
   logic [D-1:0] rem_in;
   logic [N-1:0] dvd_in;
   logic         valid_ff;
   logic [D-1:0] rem_ff;
   logic [N-1:0] dvd_ff;
   logic [S-1:0] side_ff;

   // Shift in the next dividend bit and try to subtract the divisor
   always_comb begin
      trial  = {in_rem, in_dvd[N-1]};
      diff   = {1'b0, trial} - {2'b00, divisor};
      borrow = diff[D+1];
      rem_in = borrow ? trial[D-1:0] : diff[D-1:0];
      dvd_in = {in_dvd[N-2:0], ~borrow};
   end

   // Clear the valid bit under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Advance the payload with the pipeline
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         dvd_ff  <= dvd_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_dvd   = dvd_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// ===== hdl/bapr_div_chain.sv =====
// Row of N division cells, one quotient bit per cell, most significant first.
// Depends on bapr_div_cell.
`default_nettype none

module bapr_div_chain #(
   parameter int N = 32,
   parameter int D = 16,
   parameter int S = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire logic         in_valid,
   input  wire logic [N-1:0] in_dividend,
   input  wire logic [S-1:0] in_side,
   input  wire logic [D-1:0] divisor,
   output logic              out_valid,
   output logic [N-1:0]      out_quotient,
   output logic [D-1:0]      out_remainder,
   output logic [S-1:0]      out_side
);

   logic         valid_w [0:N];
   logic [D-1:0] rem_w   [0:N];
   logic [N-1:0] dvd_w   [0:N];
   logic [S-1:0] side_w  [0:N];

   // Feed the first cell with a cleared remainder
   assign valid_w[0] = in_valid;
   assign rem_w[0]   = '0;
   assign dvd_w[0]   = in_dividend;
   assign side_w[0]  = in_side;

   // Chain the cells; each shifts the quotient bit into the dividend word
   for (genvar k = 0; k < N; k++) begin : g_cell
      bapr_div_cell #(
         .N(N),
         .D(D),
         .S(S)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (valid_w[k]),
         .in_rem   (rem_w[k]),
         .in_dvd   (dvd_w[k]),
         .in_side  (side_w[k]),
         .divisor  (divisor),
         .out_valid(valid_w[k+1]),
         .out_rem  (rem_w[k+1]),
         .out_dvd  (dvd_w[k+1]),
         .out_side (side_w[k+1])
      );
   end

   assign out_valid     = valid_w[N];
   assign out_quotient  = dvd_w[N];
   assign out_remainder = rem_w[N];
   assign out_side      = side_w[N];

endmodule

`default_nettype wire

// ===== hdl/bapr_rsp_buffer.sv =====
// Two-entry output buffer that decouples the pipeline from the result channel.
// Room is a registered flag, so no path runs from rsp ready to req ready.
// Depends on nothing outside this file.
`default_nettype none

module bapr_rsp_buffer #(
   parameter int W = 99
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] push_data,
   input  wire logic         pop_ready,
   output logic              out_valid,
   output logic [W-1:0]      out_data,
   output logic              has_room
);

   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   logic [W-1:0] head_ff;
   logic [W-1:0] tail_ff;
   logic         pop;

   assign pop = out_valid && pop_ready;

   // Track occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Move entries: head is what the channel shows
   always_ff @(posedge clock) begin
      if (pop && !push) begin
         head_ff <= tail_ff;
      end else if (push && pop) begin
         head_ff <= push_data;
      end else if (push && count_ff == 2'd0) begin
         head_ff <= push_data;
      end else if (push) begin
         tail_ff <= push_data;
      end
   end

   assign out_valid = count_ff != 2'd0;
   assign out_data  = head_ff;
   assign has_room  = count_ff != 2'd2;

endmodule

`default_nettype wire

// ===== hdl/block_aligned_range_partition.sv =====
// Block aligned range partition: for a range [start, end) and a segment
// index, returns the bounds and size of that segment when the range is cut
// into whole blocks of block_size and shared evenly over segment_count.
//
// Channels: req_ carries a query, rsp_ carries its result, one per query,
// in order. csr_ writes block_size (index 0) and segment_count (index 1);
// write only while no query is in flight.
// Throughput: one query per cycle while the output buffer has room.
// Stages in order: the entry stage, two rows of ADDR_WIDTH division cells
// (one quotient bit per cell), two multiply stages and the output buffer.
// Stall: the output buffer holds two results; while it is full the whole
// pipeline holds and req_tready is low. Otherwise a query is taken every
// cycle, also while a finished result waits on the rsp side.
// Reset: clears all valid bits and the buffer and sets both registers to 1.
// Errors give a nonzero status in rsp_tuser and all-zero rsp_tdata.
`default_nettype none

module block_aligned_range_partition #(
   parameter int ADDR_WIDTH  = bapr_pkg::ADDR_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = bapr_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // range_start, range_end, segment_index (lowest bits first), zero padded
   input  wire logic [((2*ADDR_WIDTH+COUNT_WIDTH+7)/8)*8-1:0] req_tdata,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // segment_start, segment_end, segment_size (lowest bits first), zero padded
   output logic [((3*ADDR_WIDTH+7)/8)*8-1:0]          rsp_tdata,
   // status
   output logic [bapr_pkg::STATUS_WIDTH-1:0]          rsp_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   input  wire logic                                  csr_wen,
   input  wire logic [bapr_pkg::CSR_ADDR_WIDTH-1:0]   csr_addr,
   input  wire logic [((bapr_pkg::BS_WIDTH > COUNT_WIDTH) ?
                       bapr_pkg::BS_WIDTH : COUNT_WIDTH)-1:0] csr_wdata
);

   import bapr_pkg::*;

   localparam int A        = ADDR_WIDTH;
   localparam int C        = COUNT_WIDTH;
   localparam int RSP_W    = ((3*ADDR_WIDTH+7)/8)*8;
   localparam int BUF_W    = RSP_W + STATUS_WIDTH;
   localparam int SIDE1_W  = A + C + 2*STATUS_WIDTH;
   localparam int SIDE2_W  = A + C + STATUS_WIDTH;

   // Pipeline-wide advance
   logic advance;

   // Configuration registers
   logic [BS_WIDTH-1:0] block_size_ff;
   logic [C-1:0]        segment_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff    <= BS_WIDTH'(1);
         segment_count_ff <= C'(1);
      end else if (csr_wen) begin
         unique case (csr_addr)
            REG_BLOCK_SIZE:    block_size_ff    <= csr_wdata[BS_WIDTH-1:0];
            REG_SEGMENT_COUNT: segment_count_ff <= csr_wdata[C-1:0];
            default: ;
         endcase
      end
   end

   // Entry stage: span and the error checks that need no division
   logic [A-1:0] req_start;
   logic [A-1:0] req_end;
   logic [C-1:0] req_index;
   status_type   hi_in;
   status_type   lo_in;
   logic         s0_valid_ff;
   logic [A-1:0] s0_span_ff;
   logic [A-1:0] s0_start_ff;
   logic [C-1:0] s0_index_ff;
   status_type   s0_hi_ff;
   status_type   s0_lo_ff;

   assign req_start = req_tdata[A-1:0];
   assign req_end   = req_tdata[2*A-1:A];
   assign req_index = req_tdata[2*A+C-1:2*A];

   always_comb begin
      if (block_size_ff == '0) begin
         hi_in = ST_BLOCK_ZERO;
      end else if (req_end < req_start) begin
         hi_in = ST_END_BEFORE_START;
      end else begin
         hi_in = ST_OK;
      end
      if (segment_count_ff == '0) begin
         lo_in = ST_COUNT_ZERO;
      end else if (req_index >= segment_count_ff) begin
         lo_in = ST_INDEX_RANGE;
      end else begin
         lo_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_span_ff  <= req_end - req_start;
         s0_start_ff <= req_start;
         s0_index_ff <= req_index;
         s0_hi_ff    <= hi_in;
         s0_lo_ff    <= lo_in;
      end
   end

   // First row: blocks = span / block_size
   logic               d1_valid;
   logic [A-1:0]       d1_quot;
   logic [BS_WIDTH-1:0] d1_rem;
   logic [SIDE1_W-1:0] d1_side;

   bapr_div_chain #(
      .N(A),
      .D(BS_WIDTH),
      .S(SIDE1_W)
   ) u_div_blocks (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (s0_valid_ff),
      .in_dividend  (s0_span_ff),
      .in_side      ({s0_start_ff, s0_index_ff, s0_hi_ff, s0_lo_ff}),
      .divisor      (block_size_ff),
      .out_valid    (d1_valid),
      .out_quotient (d1_quot),
      .out_remainder(d1_rem),
      .out_side     (d1_side)
   );

   // Resolve status in precedence order
   logic [A-1:0] d1_start;
   logic [C-1:0] d1_index;
   status_type   d1_hi;
   status_type   d1_lo;
   status_type   d1_status;

   always_comb begin
      d1_start = d1_side[SIDE1_W-1 -: A];
      d1_index = d1_side[2*STATUS_WIDTH +: C];
      d1_hi    = status_type'(d1_side[STATUS_WIDTH +: STATUS_WIDTH]);
      d1_lo    = status_type'(d1_side[STATUS_WIDTH-1:0]);
      if (d1_hi != ST_OK) begin
         d1_status = d1_hi;
      end else if (d1_rem != '0) begin
         d1_status = ST_NOT_MULTIPLE;
      end else begin
         d1_status = d1_lo;
      end
   end

   // Second row: per = blocks / segment_count, extra = blocks mod count
   logic               d2_valid;
   logic [A-1:0]       d2_per;
   logic [C-1:0]       d2_extra;
   logic [SIDE2_W-1:0] d2_side;

   bapr_div_chain #(
      .N(A),
      .D(C),
      .S(SIDE2_W)
   ) u_div_segments (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (d1_valid),
      .in_dividend  (d1_quot),
      .in_side      ({d1_start, d1_index, d1_status}),
      .divisor      (segment_count_ff),
      .out_valid    (d2_valid),
      .out_quotient (d2_per),
      .out_remainder(d2_extra),
      .out_side     (d2_side)
   );

   // Post stage 1: offset and length in blocks
   logic [A-1:0]   d2_start;
   logic [C-1:0]   d2_index;
   status_type     d2_status;
   logic           gets_extra;
   logic [C-1:0]   extra_before;
   logic [A+C-1:0] off_prod;
   logic [A-1:0]   p1_off_in;
   logic [A-1:0]   p1_len_in;
   logic           p1_valid_ff;
   logic [A-1:0]   p1_off_ff;
   logic [A-1:0]   p1_len_ff;
   logic [A-1:0]   p1_start_ff;
   status_type     p1_status_ff;

   always_comb begin
      d2_start     = d2_side[SIDE2_W-1 -: A];
      d2_index     = d2_side[STATUS_WIDTH +: C];
      d2_status    = status_type'(d2_side[STATUS_WIDTH-1:0]);
      gets_extra   = d2_index < d2_extra;
      extra_before = gets_extra ? d2_index : d2_extra;
      // offset = index * per + min(index, extra)
      off_prod     = {{C{1'b0}}, d2_per} * {{A{1'b0}}, d2_index}
                     + {{A{1'b0}}, extra_before};
      p1_off_in    = off_prod[A-1:0];
      p1_len_in    = d2_per + {{(A-1){1'b0}}, gets_extra};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_off_ff    <= p1_off_in;
         p1_len_ff    <= p1_len_in;
         p1_start_ff  <= d2_start;
         p1_status_ff <= d2_status;
      end
   end

   // Post stage 2: scale blocks to elements
   logic [A+BS_WIDTH-1:0] off_elems;
   logic [A+BS_WIDTH-1:0] len_elems;
   logic                  p2_valid_ff;
   logic [A-1:0]          p2_off_ff;
   logic [A-1:0]          p2_size_ff;
   logic [A-1:0]          p2_start_ff;
   status_type            p2_status_ff;

   always_comb begin
      off_elems = {{BS_WIDTH{1'b0}}, p1_off_ff} * {{A{1'b0}}, block_size_ff};
      len_elems = {{BS_WIDTH{1'b0}}, p1_len_ff} * {{A{1'b0}}, block_size_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (advance) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p2_off_ff    <= off_elems[A-1:0];
         p2_size_ff   <= len_elems[A-1:0];
         p2_start_ff  <= p1_start_ff;
         p2_status_ff <= p1_status_ff;
      end
   end

   // Form the result word; errors give zero fields
   logic [A-1:0]     seg_start;
   logic [A-1:0]     seg_end;
   logic [RSP_W-1:0] rsp_word;
   logic [BUF_W-1:0] buf_out;

   always_comb begin
      seg_start = p2_start_ff + p2_off_ff;
      seg_end   = seg_start + p2_size_ff;
      rsp_word  = '0;
      if (p2_status_ff == ST_OK) begin
         rsp_word[A-1:0]     = seg_start;
         rsp_word[2*A-1:A]   = seg_end;
         rsp_word[3*A-1:2*A] = p2_size_ff;
      end
   end

   bapr_rsp_buffer #(
      .W(BUF_W)
   ) u_rsp_buffer (
      .clock    (clock),
      .reset    (reset),
      .push     (advance && p2_valid_ff),
      .push_data({p2_status_ff, rsp_word}),
      .pop_ready(rsp_tready),
      .out_valid(rsp_tvalid),
      .out_data (buf_out),
      .has_room (advance)
   );

   assign rsp_tdata  = buf_out[RSP_W-1:0];
   assign rsp_tuser  = buf_out[BUF_W-1 -: STATUS_WIDTH];
   assign req_tready = advance;

   // An error result carries no bounds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_OK) |-> (rsp_tdata == '0))
      else $error("error result with nonzero fields");

   // A good segment ends where its size says
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_OK) |->
      (rsp_tdata[2*A-1:A] == A'(rsp_tdata[A-1:0] + rsp_tdata[3*A-1:2*A])))
      else $error("segment end does not match start plus size");

   // Input is held off only while results are waiting
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with no pending result");

   // A result is never dropped from the buffer without a transfer
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("pending result vanished");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for block_aligned_range_partition: drives partition queries
// and register writes, predicts each segment result and checks it on the rsp side.
// Depends on bapr_pkg (status codes, register indexes) and the block's RTL.
`default_nettype none

module tb_top;
   import bapr_pkg::*;

   localparam int ADDR_W        = 32;
   localparam int COUNT_W       = 16;
   localparam int REQ_W         = 2*ADDR_W + COUNT_W;
   localparam int RSP_W         = 3*ADDR_W;
   localparam int QUIET_LIMIT   = 2000;
   localparam int ITEMS_PER_SET = 140;
   localparam int RANDOM_SETS   = 10;

   typedef struct {
      logic [ADDR_W-1:0] seg_start;
      logic [ADDR_W-1:0] seg_end;
      logic [ADDR_W-1:0] seg_size;
      status_type        status;
   } segment_type;

   // Track the register copy and the queue of segments still to arrive
   class partition_scoreboard;
      bit [BS_WIDTH-1:0] block_size;
      bit [COUNT_W-1:0]  segment_count;
      segment_type       segment_q[$];
      int unsigned       errors;

      function new();
         block_size    = 1;
         segment_count = 1;
         errors        = 0;
      endfunction

      function void set_config(bit [BS_WIDTH-1:0] bs, bit [COUNT_W-1:0] cnt);
         block_size    = bs;
         segment_count = cnt;
      endfunction

      function int pending();
         return segment_q.size();
      endfunction

      // Compute the segment for one accepted query
      function void note_query(logic [REQ_W-1:0] query);
         longint unsigned first, last, idx, blocks, per, rem, len_blocks, off_blocks;
         longint unsigned start_elem, size_elem;
         segment_type seg;
         first = query[ADDR_W-1:0];
         last  = query[2*ADDR_W-1:ADDR_W];
         idx   = query[REQ_W-1:2*ADDR_W];
         seg   = '{seg_start: '0, seg_end: '0, seg_size: '0, status: ST_OK};
         if (block_size == 0) begin
            seg.status = ST_BLOCK_ZERO;
         end else if (last < first) begin
            seg.status = ST_END_BEFORE_START;
         end else if (((last - first) % block_size) != 0) begin
            seg.status = ST_NOT_MULTIPLE;
         end else if (segment_count == 0) begin
            seg.status = ST_COUNT_ZERO;
         end else if (idx >= segment_count) begin
            seg.status = ST_INDEX_RANGE;
         end else begin
            blocks = (last - first) / block_size;
            per    = blocks / segment_count;
            rem    = blocks - per * segment_count;
            // leading segments carry one extra block each
            if (idx < rem) begin
               len_blocks = per + 1;
               off_blocks = len_blocks * idx;
            end else begin
               len_blocks = per;
               off_blocks = rem * (per + 1) + (idx - rem) * per;
            end
            start_elem    = first + off_blocks * block_size;
            size_elem     = len_blocks * block_size;
            seg.seg_start = ADDR_W'(start_elem);
            seg.seg_size  = ADDR_W'(size_elem);
            seg.seg_end   = ADDR_W'(start_elem + size_elem);
         end
         segment_q.push_back(seg);
      endfunction

      function void compare(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         end
      endfunction

      // Match one result transfer against the oldest outstanding segment
      function void check_result(logic [RSP_W-1:0] data, logic [STATUS_WIDTH-1:0] status);
         segment_type seg;
         if (segment_q.size() == 0) begin
            errors++;
            $display("%0t: result with no query outstanding, actual %h status %0d",
                     $time, data, status);
         end else begin
            seg = segment_q.pop_front();
            compare("segment_start", seg.seg_start, data[ADDR_W-1:0]);
            compare("segment_end", seg.seg_end, data[2*ADDR_W-1:ADDR_W]);
            compare("segment_size", seg.seg_size, data[3*ADDR_W-1:2*ADDR_W]);
            compare("status", ADDR_W'(seg.status), ADDR_W'(status));
         end
      endfunction
   endclass

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic [REQ_W-1:0]          req_tdata  = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [RSP_W-1:0]          rsp_tdata;
   logic [STATUS_WIDTH-1:0]   rsp_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic                      csr_wen    = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr   = '0;
   logic [COUNT_W-1:0]        csr_wdata  = '0;

   partition_scoreboard sb = new();

   int unsigned       burst_left = 0;
   int unsigned       quiet_cycles = 0;
   int unsigned       stall_mode = 0;
   int unsigned       stall_left = 0;
   int unsigned       stall_phase = 0;
   bit [BS_WIDTH-1:0] set_bs;
   bit [COUNT_W-1:0]  set_cnt;

   block_aligned_range_partition #(
      .ADDR_WIDTH (ADDR_W),
      .COUNT_WIDTH(COUNT_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Accept results and stall on a mode that changes every so often
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser);
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
         end
         stall_left--;
         stall_phase++;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 7) == 0);
            default: rsp_tready <= (stall_phase % 4 == 0);
         endcase
      end
   end

   // End the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [REQ_W-1:0] pack_query(logic [ADDR_W-1:0] first,
                                                   logic [ADDR_W-1:0] last,
                                                   logic [COUNT_W-1:0] idx);
      return {idx, last, first};
   endfunction

   // Mostly well-formed ranges, with misaligned, reversed, out-of-range and raw queries
   function automatic logic [REQ_W-1:0] random_query(bit [BS_WIDTH-1:0] bs,
                                                     bit [COUNT_W-1:0] cnt);
      longint unsigned bsz, maxblk, blocks, span, first, last, off, cap;
      int unsigned     kind;
      logic [COUNT_W-1:0] idx;
      bsz    = (bs == 0) ? 1 : bs;
      maxblk = 64'hFFFF_FFFF / bsz;
      kind   = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
         0: begin
            cap    = 4 * longint'(cnt) + 4;
            cap    = (cap > maxblk) ? maxblk : cap;
            blocks = {$urandom, $urandom} % (cap + 1);
         end
         1: blocks = maxblk;
         default: blocks = {$urandom, $urandom} % (maxblk + 1);
      endcase
      span  = blocks * bsz;
      first = {$urandom, $urandom} % (64'h1_0000_0000 - span);
      last  = first + span;
      idx   = (cnt == 0) ? COUNT_W'($urandom) : COUNT_W'($urandom_range(0, cnt - 1));
      if (kind >= 70 && kind < 78 && bsz > 1) begin
         off = $urandom_range(1, bsz - 1);
         if (first >= off)
            first = first - off;
         else if (last + off <= 64'hFFFF_FFFF)
            last = last + off;
      end else if (kind >= 78 && kind < 86) begin
         first = $urandom_range(1, 32'hFFFF_FFFF);
         last  = $urandom % first;
      end else if (kind >= 86 && kind < 94) begin
         idx = COUNT_W'($urandom_range(cnt, 16'hFFFF));
      end else if (kind >= 94) begin
         first = $urandom;
         last  = $urandom;
         idx   = COUNT_W'($urandom);
      end
      return pack_query(first[ADDR_W-1:0], last[ADDR_W-1:0], idx);
   endfunction

   // Present one query, idling between bursts, and hold until the transfer
   task automatic send_query(logic [REQ_W-1:0] query);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tdata  <= query;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_query(query);
   endtask

   // Drop valid and hold until every outstanding segment has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic program_partition(bit [BS_WIDTH-1:0] bs, bit [COUNT_W-1:0] cnt);
      csr_wen   <= 1'b1;
      csr_addr  <= REG_BLOCK_SIZE;
      csr_wdata <= bs;
      @(posedge clock);
      csr_addr  <= REG_SEGMENT_COUNT;
      csr_wdata <= cnt;
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.set_config(bs, cnt);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset values: one block per element, a single segment
      send_query(pack_query(32'h0, 32'h0, 16'h0));
      send_query(pack_query(32'h0, 32'hFFFF_FFFF, 16'h0));
      send_query(pack_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0));
      send_query(pack_query(32'hFFFF_FFFF, 32'h0, 16'h0));
      send_query(pack_query(32'd5, 32'd9, 16'd1));
      send_query(pack_query(32'd5, 32'd9, 16'hFFFF));

      // zero block size wins over every other error
      settle();
      program_partition(16'd0, 16'd1);
      send_query(pack_query(32'd0, 32'd16, 16'd0));
      send_query(pack_query(32'd9, 32'd3, 16'hFFFF));

      // zero segment count, misaligned and reversed ranges
      settle();
      program_partition(16'd16, 16'd0);
      send_query(pack_query(32'd0, 32'd32, 16'd0));
      send_query(pack_query(32'd0, 32'd33, 16'd0));
      send_query(pack_query(32'd40, 32'd8, 16'd0));
      send_query(pack_query(32'd100, 32'd100, 16'd0));

      // widest registers over the whole address space
      settle();
      program_partition(16'hFFFF, 16'hFFFF);
      send_query(pack_query(32'h0, 32'hFFFF_FFFF, 16'hFFFE));
      send_query(pack_query(32'h0, 32'hFFFF_FFFF, 16'h0));
      send_query(pack_query(32'h0, 32'hFFFF_FFFF, 16'h1));
      send_query(pack_query(32'h0, 32'hFFFF_FFFF, 16'h2));
      send_query(pack_query(32'h0, 32'hFFFF_FFFF, 16'hFFFF));

      // seven blocks over five segments: two long ones, then short ones
      settle();
      program_partition(16'd3, 16'd5);
      for (int i = 0; i < 5; i++)
         send_query(pack_query(32'd10, 32'd31, i[COUNT_W-1:0]));
      send_query(pack_query(32'd10, 32'd32, 16'd0));
      send_query(pack_query(32'd0, 32'd0, 16'd4));

      // random register sets, extremes first
      for (int set_num = 0; set_num < RANDOM_SETS; set_num++) begin
         settle();
         case (set_num)
            0: begin
               set_bs  = 16'd1;
               set_cnt = 16'hFFFF;
            end
            1: begin
               set_bs  = 16'hFFFF;
               set_cnt = 16'd1;
            end
            default: begin
               case ($urandom_range(0, 9))
                  0: set_bs = 16'd0;
                  1: set_bs = 16'd1;
                  2: set_bs = 16'hFFFF;
                  3, 4, 5, 6: set_bs = BS_WIDTH'($urandom_range(2, 64));
                  default: set_bs = BS_WIDTH'($urandom);
               endcase
               case ($urandom_range(0, 9))
                  0: set_cnt = 16'd0;
                  1: set_cnt = 16'd1;
                  2: set_cnt = 16'hFFFF;
                  3, 4, 5, 6: set_cnt = COUNT_W'($urandom_range(2, 40));
                  default: set_cnt = COUNT_W'($urandom);
               endcase
            end
         endcase
         program_partition(set_bs, set_cnt);
         repeat (ITEMS_PER_SET) send_query(random_query(set_bs, set_cnt));
      end

      settle();
      repeat (60) @(posedge clock);
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
